// File: rtl/hsvrgbw_pkg.sv
//------------------------------------------------------------------------------
// HSV to RGBW converter package
// Shared payload types, sextant codes and fixed constants of the converter.
//------------------------------------------------------------------------------
`default_nettype none

package hsvrgbw_pkg;

  localparam int unsigned DataWidth = 16;

  localparam logic [DataWidth-1:0] SEXTANT_SIZE = 16'd10923;
  localparam logic [DataWidth-1:0] FULL_SCALE   = 16'hFFFF;

  // Lower hue bound of each sextant above the first.
  localparam logic [DataWidth-1:0] SEXT_BOUND_1 = 16'(1 * 10923);
  localparam logic [DataWidth-1:0] SEXT_BOUND_2 = 16'(2 * 10923);
  localparam logic [DataWidth-1:0] SEXT_BOUND_3 = 16'(3 * 10923);
  localparam logic [DataWidth-1:0] SEXT_BOUND_4 = 16'(4 * 10923);
  localparam logic [DataWidth-1:0] SEXT_BOUND_5 = 16'(5 * 10923);

  // Register map of the configuration port.
  localparam logic REG_WHITE_CTRL = 1'b0;

  typedef enum logic [2:0] {
    SEXT_0 = 3'd0,
    SEXT_1 = 3'd1,
    SEXT_2 = 3'd2,
    SEXT_3 = 3'd3,
    SEXT_4 = 3'd4,
    SEXT_5 = 3'd5
  } sextant_t;

  // After the sextant split.
  typedef struct packed {
    sextant_t             sextant;
    logic [DataWidth-1:0] frac;
    logic [DataWidth-1:0] sat;
    logic [DataWidth-1:0] val;
    logic [DataWidth-1:0] p;
  } sector_t;

  // After the saturation products.
  typedef struct packed {
    sextant_t             sextant;
    logic [DataWidth-1:0] val;
    logic [DataWidth-1:0] p;
    logic [DataWidth-1:0] sat_frac;
    logic [DataWidth-1:0] sat_rfrac;
  } satprod_t;

  // Helper terms ready for routing.
  typedef struct packed {
    sextant_t             sextant;
    logic [DataWidth-1:0] val;
    logic [DataWidth-1:0] p;
    logic [DataWidth-1:0] q;
    logic [DataWidth-1:0] t;
  } terms_t;

  typedef struct packed {
    logic [DataWidth-1:0] red;
    logic [DataWidth-1:0] green;
    logic [DataWidth-1:0] blue;
    logic [DataWidth-1:0] white;
  } rgbw_t;

  function automatic logic [DataWidth-1:0] sextant_base(input sextant_t s);
    logic [DataWidth-1:0] base;
    unique case (s)
      SEXT_0:  base = '0;
      SEXT_1:  base = SEXT_BOUND_1;
      SEXT_2:  base = SEXT_BOUND_2;
      SEXT_3:  base = SEXT_BOUND_3;
      SEXT_4:  base = SEXT_BOUND_4;
      SEXT_5:  base = SEXT_BOUND_5;
      default: base = SEXT_BOUND_5;
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

// File: rtl/hsvrgbw_sector.sv
//------------------------------------------------------------------------------
// HSV to RGBW sextant stage
// Splits hue into sextant and scaled remainder and forms the p term.
//------------------------------------------------------------------------------
`default_nettype none

module hsvrgbw_sector (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  up_vld,
  input  wire logic [15:0]           hue,
  input  wire logic [15:0]           sat,
  input  wire logic [15:0]           val,
  output      logic                  up_stall,
  output      logic                  dn_vld,
  output      hsvrgbw_pkg::sector_t  dn_data,
  input  wire logic                  dn_stall
);
  import hsvrgbw_pkg::*;

  logic                 vld_r;
  sector_t              data_r;
  sector_t              data_nxt;
  logic                 adv;
  sextant_t             sext;
  logic [DataWidth-1:0] rem;
  logic [31:0]          p_prod;

  assign adv = !vld_r || !dn_stall;

  always_comb begin
    priority if (hue >= SEXT_BOUND_5) begin
      sext = SEXT_5;
    end else if (hue >= SEXT_BOUND_4) begin
      sext = SEXT_4;
    end else if (hue >= SEXT_BOUND_3) begin
      sext = SEXT_3;
    end else if (hue >= SEXT_BOUND_2) begin
      sext = SEXT_2;
    end else if (hue >= SEXT_BOUND_1) begin
      sext = SEXT_1;
    end else begin
      sext = SEXT_0;
    end
  end

  assign rem    = hue - sextant_base(sext);
  assign p_prod = val * (FULL_SCALE - sat);

  always_comb begin
    data_nxt.sextant = sext;
    // The remainder stays below the sextant size, so times six fits 16 bits.
    data_nxt.frac    = (rem << 2) + (rem << 1);
    data_nxt.sat     = sat;
    data_nxt.val     = val;
    data_nxt.p       = p_prod[31:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign up_stall = !adv;
  assign dn_vld   = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// File: rtl/hsvrgbw_scale.sv
//------------------------------------------------------------------------------
// HSV to RGBW scaling stages
// Two multiply stages that form the q and t helper terms.
//------------------------------------------------------------------------------
`default_nettype none

module hsvrgbw_scale (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  up_vld,
  input  wire hsvrgbw_pkg::sector_t  up_data,
  output      logic                  up_stall,
  output      logic                  dn_vld,
  output      hsvrgbw_pkg::terms_t   dn_data,
  input  wire logic                  dn_stall
);
  import hsvrgbw_pkg::*;

  logic        vld_a_r;
  logic        vld_b_r;
  satprod_t    a_r;
  satprod_t    a_nxt;
  terms_t      b_r;
  terms_t      b_nxt;
  logic        adv_a;
  logic        adv_b;
  logic [31:0] sf_prod;
  logic [31:0] srf_prod;
  logic [31:0] q_prod;
  logic [31:0] t_prod;

  assign adv_b = !vld_b_r || !dn_stall;
  assign adv_a = !vld_a_r || adv_b;

  // First stage: saturation times the remainder and its complement.
  assign sf_prod  = up_data.sat * up_data.frac;
  assign srf_prod = up_data.sat * (FULL_SCALE - up_data.frac);

  always_comb begin
    a_nxt.sextant   = up_data.sextant;
    a_nxt.val       = up_data.val;
    a_nxt.p         = up_data.p;
    a_nxt.sat_frac  = sf_prod[31:16];
    a_nxt.sat_rfrac = srf_prod[31:16];
  end

  // Second stage: value times the complemented products.
  assign q_prod = a_r.val * (FULL_SCALE - a_r.sat_frac);
  assign t_prod = a_r.val * (FULL_SCALE - a_r.sat_rfrac);

  always_comb begin
    b_nxt.sextant = a_r.sextant;
    b_nxt.val     = a_r.val;
    b_nxt.p       = a_r.p;
    b_nxt.q       = q_prod[31:16];
    b_nxt.t       = t_prod[31:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (adv_a) begin
        vld_a_r <= up_vld;
      end
      if (adv_b) begin
        vld_b_r <= vld_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_r <= a_nxt;
    end
    if (adv_b) begin
      b_r <= b_nxt;
    end
  end

  assign up_stall = !adv_a;
  assign dn_vld   = vld_b_r;
  assign dn_data  = b_r;

endmodule

`default_nettype wire

// File: rtl/hsvrgbw_white.sv
//------------------------------------------------------------------------------
// HSV to RGBW routing and white stages
// Routes p, q and t by sextant, finds white and removes it from the colors.
//------------------------------------------------------------------------------
`default_nettype none

module hsvrgbw_white (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 white_en,
  input  wire logic                 up_vld,
  input  wire hsvrgbw_pkg::terms_t  up_data,
  output      logic                 up_stall,
  output      logic                 dn_vld,
  output      hsvrgbw_pkg::rgbw_t   dn_data,
  input  wire logic                 dn_stall
);
  import hsvrgbw_pkg::*;

  logic                 vld_a_r;
  logic                 vld_b_r;
  rgbw_t                a_r;
  rgbw_t                a_nxt;
  rgbw_t                b_r;
  rgbw_t                b_nxt;
  logic                 adv_a;
  logic                 adv_b;
  logic [DataWidth-1:0] r;
  logic [DataWidth-1:0] g;
  logic [DataWidth-1:0] b;
  logic [DataWidth-1:0] min_rg;
  logic [DataWidth-1:0] min_rgb;

  assign adv_b = !vld_b_r || !dn_stall;
  assign adv_a = !vld_a_r || adv_b;

  always_comb begin
    unique case (up_data.sextant)
      SEXT_0: begin
        r = up_data.val; g = up_data.t;   b = up_data.p;
      end
      SEXT_1: begin
        r = up_data.q;   g = up_data.val; b = up_data.p;
      end
      SEXT_2: begin
        r = up_data.p;   g = up_data.val; b = up_data.t;
      end
      SEXT_3: begin
        r = up_data.p;   g = up_data.q;   b = up_data.val;
      end
      SEXT_4: begin
        r = up_data.t;   g = up_data.p;   b = up_data.val;
      end
      default: begin
        r = up_data.val; g = up_data.p;   b = up_data.q;
      end
    endcase
  end

  assign min_rg  = (g < r) ? g : r;
  assign min_rgb = (b < min_rg) ? b : min_rg;

  always_comb begin
    a_nxt.red   = r;
    a_nxt.green = g;
    a_nxt.blue  = b;
    a_nxt.white = white_en ? min_rgb : '0;
  end

  // With white forced to zero the subtraction leaves the colors unchanged.
  always_comb begin
    b_nxt.red   = a_r.red   - a_r.white;
    b_nxt.green = a_r.green - a_r.white;
    b_nxt.blue  = a_r.blue  - a_r.white;
    b_nxt.white = a_r.white;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (adv_a) begin
        vld_a_r <= up_vld;
      end
      if (adv_b) begin
        vld_b_r <= vld_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_r <= a_nxt;
    end
    if (adv_b) begin
      b_r <= b_nxt;
    end
  end

  assign up_stall = !adv_a;
  assign dn_vld   = vld_b_r;
  assign dn_data  = b_r;

endmodule

`default_nettype wire

// File: rtl/hsv_to_rgbw_converter.sv
//------------------------------------------------------------------------------
// HSV to RGBW converter
// Five-stage pipeline from a 16-bit HSV triple to red, green, blue and white.
//------------------------------------------------------------------------------
// An input transfer passes the sector register, two scale registers and two
// white registers before its result is on the output. Throughput is one
// transfer per cycle unless stalled; each multiply stage holds one item.
// A synchronous active-low reset empties the pipeline and sets white
// extraction to enabled; payload registers are not reset.
//------------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgbw_converter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [15:0] in_hue,
  input  wire logic [15:0] in_saturation,
  input  wire logic [15:0] in_brightness,
  // Result channel.
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [15:0] out_red,
  output      logic [15:0] out_green,
  output      logic [15:0] out_blue,
  output      logic [15:0] out_white,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);
  import hsvrgbw_pkg::*;

  // The single control register holds the white extraction enable. Only bit 0
  // of the write data is kept, and writes to any other word are ignored.
  logic white_en_r;
  logic cfg_wr;
  logic cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == REG_WHITE_CTRL);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_en_r <= 1'b1;
    end else if (cfg_wr && cfg_hit) begin
      white_en_r <= pwdata[0];
    end
  end

  assign prdata = cfg_hit ? {31'b0, white_en_r} : '0;

  // Each stage advances when it is empty or when the stage after it moves,
  // so bubbles close up behind a held result, while full stages behind it wait.
  logic    sec_vld;
  sector_t sec_data;
  logic    sec_stall;
  logic    scl_vld;
  terms_t  scl_data;
  logic    scl_stall;
  logic    wht_vld;
  rgbw_t   wht_data;

  // Stage one: sextant, remainder times six, and the p term.
  hsvrgbw_sector u_sector (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_vld   (in_valid),
    .hue      (in_hue),
    .sat      (in_saturation),
    .val      (in_brightness),
    .up_stall (in_stall),
    .dn_vld   (sec_vld),
    .dn_data  (sec_data),
    .dn_stall (sec_stall)
  );

  // Stages two and three: the two layers of products behind q and t.
  hsvrgbw_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_vld   (sec_vld),
    .up_data  (sec_data),
    .up_stall (sec_stall),
    .dn_vld   (scl_vld),
    .dn_data  (scl_data),
    .dn_stall (scl_stall)
  );

  // Stages four and five: routing plus minimum, then white removal. The last
  // stage is the output register.
  hsvrgbw_white u_white (
    .clk      (clk),
    .rst_n    (rst_n),
    .white_en (white_en_r),
    .up_vld   (scl_vld),
    .up_data  (scl_data),
    .up_stall (scl_stall),
    .dn_vld   (wht_vld),
    .dn_data  (wht_data),
    .dn_stall (out_stall)
  );

  assign out_valid = wht_vld;
  assign out_red   = wht_data.red;
  assign out_green = wht_data.green;
  assign out_blue  = wht_data.blue;
  assign out_white = wht_data.white;

endmodule

`default_nettype wire
